@@ rtl/core/bps_pkg.sv @@
`default_nettype none
package bps_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int CORDIC_RUN = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
	localparam int CNT_W = 6;

	localparam logic signed [24:0] DEG90 = 25'sd5898240;
	localparam logic signed [24:0] DEG180 = 25'sd11796480;

	localparam int NUM_CFG = 8;
	localparam logic [2:0] CFG_START_POS_X = 3'd0;
	localparam logic [2:0] CFG_START_POS_Y = 3'd1;
	localparam logic [2:0] CFG_START_POS_Z = 3'd2;
	localparam logic [2:0] CFG_START_VEL_X = 3'd3;
	localparam logic [2:0] CFG_START_VEL_Y = 3'd4;
	localparam logic [2:0] CFG_START_VEL_Z = 3'd5;
	localparam logic [2:0] CFG_START_LIFE = 3'd6;
	localparam logic [2:0] CFG_GRAVITY = 3'd7;

	localparam logic [31:0] RST_START_LIFE = 32'd65536;
	localparam logic [31:0] RST_GRAVITY = 32'd642908;

	localparam logic REQ_SPAWN = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOVE,
		ST_DIFF,
		ST_SQ,
		ST_TURN_INIT,
		ST_TURN,
		ST_TILT_INIT,
		ST_TILT_SQ,
		ST_ISQRT,
		ST_TILT,
		ST_GRAV,
		ST_DONE
	} state_t;

	// Arctangent of 2^-i in degrees, Q16.16, rounded.
	function automatic logic signed [31:0] atan_deg(input logic [4:0] idx);
		logic signed [31:0] r;
		case (idx)
			5'd0: r = 32'sd2949120;
			5'd1: r = 32'sd1740967;
			5'd2: r = 32'sd919879;
			5'd3: r = 32'sd466945;
			5'd4: r = 32'sd234379;
			5'd5: r = 32'sd117304;
			5'd6: r = 32'sd58666;
			5'd7: r = 32'sd29335;
			5'd8: r = 32'sd14668;
			5'd9: r = 32'sd7334;
			5'd10: r = 32'sd3667;
			5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;
			5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;
			5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;
			5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;
			5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;
			5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Smallest right shift that brings a magnitude below 2^30.
	function automatic logic [1:0] prescale(input logic [31:0] m);
		logic [1:0] s;
		if (m[31]) s = 2'd2;
		else if (m[30]) s = 2'd1;
		else s = 2'd0;
		return s;
	endfunction

	function automatic logic signed [24:0] clamp90(input logic signed [31:0] z);
		logic signed [24:0] r;
		if (z < 0) r = 25'sd0;
		else if (z > 32'(DEG90)) r = DEG90;
		else r = z[24:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/bps_if.sv @@
`default_nettype none
interface bps_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [15:0] time_delta;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic signed [31:0] cam_z;
	modport source(output valid, req_type, time_delta, cam_x, cam_y, cam_z, input ready);
	modport sink(input valid, req_type, time_delta, cam_x, cam_y, cam_z, output ready);
endinterface

interface bps_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] new_x;
	logic signed [31:0] new_y;
	logic signed [31:0] new_z;
	logic signed [24:0] turn_angle;
	logic signed [24:0] tilt_angle;
	logic [63:0] camera_distance_sq;
	logic signed [31:0] life_left;
	modport source(output valid, new_x, new_y, new_z, turn_angle, tilt_angle,
		camera_distance_sq, life_left, input ready);
	modport sink(input valid, new_x, new_y, new_z, turn_angle, tilt_angle,
		camera_distance_sq, life_left, output ready);
endinterface
`default_nettype wire

@@ rtl/core/billboard_particle_step_top.sv @@
// Billboard particle update for a single particle.
// Channels: in_ch carries a request (spawn or step with time delta and camera
// position), out_ch returns one result transaction per request: new position,
// turn and tilt angles in degrees, squared camera distance and life left.
// Configuration is to be written through cfg_we / cfg_idx / cfg_data while
// idle; the block itself does not enforce this. A spawn result passes through
// ST_DONE into the output register. A step runs on one shared shift-add
// multiplier, one CORDIC adder set and one square-root stage in sequence:
// the three velocity products, the three distance squares, the turn angle,
// the two tilt squares, the square root, the tilt angle and gravity.
// The block takes one request at a time; ready is high only when idle, so
// it takes no new request until the result is in the output register.
// The finished result sits in an output register, so a new request may be
// taken while the receiver stalls; the next result then waits for it.
// Reset clears the particle state to zero and the configuration registers
// to their defaults, and empties the output register.
`default_nettype none
module billboard_particle_step_top (
	input wire logic clk,
	input wire logic arst_n,
	bps_req_if.sink in_ch,
	bps_res_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_idx,
	input wire logic [31:0] cfg_data
);

	bps_pkg::state_t state_q, state_d;

	logic [31:0] cfg_q [bps_pkg::NUM_CFG];
	logic [31:0] pos_q [3];
	logic [31:0] vel_q [3];
	logic [31:0] life_q;

	logic [15:0] dt_q;
	logic [31:0] cam_q [3];
	logic [1:0] k_q;
	logic [bps_pkg::CNT_W-1:0] cnt_q;

	logic signed [65:0] acc_q, mcand_q;
	logic [31:0] mplier_q;

	logic [31:0] a_q [3];
	logic v0_le0_q, v2_neg_q, v1_ge0_q;
	logic [31:0] hz_q, hy_q;

	logic signed [35:0] cx_q, cy_q;
	logic signed [31:0] cz_q;

	logic [63:0] n_q, res_q, bit_q;

	logic signed [24:0] turn_q, tilt_q;
	logic [63:0] dist_q;

	logic out_valid_q;
	logic signed [31:0] o_x_q, o_y_q, o_z_q, o_life_q;
	logic signed [24:0] o_turn_q, o_tilt_q;
	logic [63:0] o_dist_q;

	// control strobes
	logic accept, mul_done, cordic_done, out_load;

	logic signed [32:0] diff [3];
	logic [31:0] m01, m012, max02;
	logic [1:0] s_turn, s_tilt;
	logic signed [35:0] cdx, cdy;
	logic signed [31:0] ctab;
	logic [63:0] trial;
	logic signed [24:0] turn_ang, tilt_ang;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			diff[k] = {cam_q[k][31], cam_q[k]} - {pos_q[k][31], pos_q[k]};
		end
	end

	assign m01 = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
	assign m012 = (a_q[2] > m01) ? a_q[2] : m01;
	assign max02 = (a_q[0] > a_q[2]) ? a_q[0] : a_q[2];
	assign s_turn = bps_pkg::prescale(max02);
	assign s_tilt = bps_pkg::prescale(m012);

	assign cdx = cy_q >>> cnt_q[4:0];
	assign cdy = cx_q >>> cnt_q[4:0];
	assign ctab = bps_pkg::atan_deg(cnt_q[4:0]);
	assign trial = res_q + bit_q;

	always_comb begin
		turn_ang = bps_pkg::clamp90(cz_q);
		if (v2_neg_q) turn_ang = bps_pkg::DEG180 - turn_ang;
		tilt_ang = bps_pkg::clamp90(cz_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bps_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (in_ch.req_type == bps_pkg::REQ_SPAWN) ?
						bps_pkg::ST_DONE : bps_pkg::ST_MOVE;
				end
			end
			bps_pkg::ST_MOVE: begin
				if (mul_done && k_q == 2'd2) state_d = bps_pkg::ST_DIFF;
			end
			bps_pkg::ST_DIFF: state_d = bps_pkg::ST_SQ;
			bps_pkg::ST_SQ: begin
				if (mul_done && k_q == 2'd2) state_d = bps_pkg::ST_TURN_INIT;
			end
			bps_pkg::ST_TURN_INIT: begin
				state_d = (a_q[0] == '0 && a_q[2] == '0) ?
					bps_pkg::ST_TILT_INIT : bps_pkg::ST_TURN;
			end
			bps_pkg::ST_TURN: begin
				if (cordic_done) state_d = bps_pkg::ST_TILT_INIT;
			end
			bps_pkg::ST_TILT_INIT: state_d = bps_pkg::ST_TILT_SQ;
			bps_pkg::ST_TILT_SQ: begin
				if (mul_done && k_q == 2'd1) state_d = bps_pkg::ST_ISQRT;
			end
			bps_pkg::ST_ISQRT: begin
				if (bit_q == '0) begin
					state_d = (res_q == '0 && hy_q == '0) ?
						bps_pkg::ST_GRAV : bps_pkg::ST_TILT;
				end
			end
			bps_pkg::ST_TILT: begin
				if (cordic_done) state_d = bps_pkg::ST_GRAV;
			end
			bps_pkg::ST_GRAV: begin
				if (mul_done) state_d = bps_pkg::ST_DONE;
			end
			bps_pkg::ST_DONE: begin
				if (out_load) state_d = bps_pkg::ST_IDLE;
			end
			default: state_d = bps_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ch.ready = (state_q == bps_pkg::ST_IDLE);
		accept = in_ch.valid && (state_q == bps_pkg::ST_IDLE);
		mul_done = (mplier_q == '0);
		cordic_done = (cnt_q == bps_pkg::CNT_W'(bps_pkg::CORDIC_RUN));
		out_load = (state_q == bps_pkg::ST_DONE) && (!out_valid_q || out_ch.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < bps_pkg::NUM_CFG; i++) begin
				case (3'(i))
					bps_pkg::CFG_START_LIFE: cfg_q[i] <= bps_pkg::RST_START_LIFE;
					bps_pkg::CFG_GRAVITY: cfg_q[i] <= bps_pkg::RST_GRAVITY;
					default: cfg_q[i] <= '0;
				endcase
			end
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
			life_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) cfg_q[cfg_idx] <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;

			if (accept && in_ch.req_type == bps_pkg::REQ_SPAWN) begin
				pos_q[0] <= cfg_q[bps_pkg::CFG_START_POS_X];
				pos_q[1] <= cfg_q[bps_pkg::CFG_START_POS_Y];
				pos_q[2] <= cfg_q[bps_pkg::CFG_START_POS_Z];
				vel_q[0] <= cfg_q[bps_pkg::CFG_START_VEL_X];
				vel_q[1] <= cfg_q[bps_pkg::CFG_START_VEL_Y];
				vel_q[2] <= cfg_q[bps_pkg::CFG_START_VEL_Z];
				life_q <= cfg_q[bps_pkg::CFG_START_LIFE];
			end
			if (state_q == bps_pkg::ST_MOVE && mul_done) begin
				pos_q[k_q] <= pos_q[k_q] + acc_q[47:16];
			end
			if (state_q == bps_pkg::ST_GRAV && mul_done) begin
				vel_q[1] <= vel_q[1] - acc_q[47:16];
				life_q <= life_q - {16'd0, dt_q};
			end
		end
	end

	// Datapath: shared multiplier, CORDIC and square-root registers.
	always_ff @(posedge clk) begin
		if (mplier_q != '0) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end

		case (state_q)
			bps_pkg::ST_IDLE: begin
				if (accept) begin
					dt_q <= in_ch.time_delta;
					cam_q[0] <= in_ch.cam_x;
					cam_q[1] <= in_ch.cam_y;
					cam_q[2] <= in_ch.cam_z;
					turn_q <= '0;
					tilt_q <= '0;
					dist_q <= '0;
					k_q <= 2'd0;
					acc_q <= '0;
					mcand_q <= {{34{vel_q[0][31]}}, vel_q[0]};
					// A spawn leaves the multiplier empty so that it is idle again at the
					// next request.
					mplier_q <= (in_ch.req_type == bps_pkg::REQ_STEP) ?
						{16'd0, in_ch.time_delta} : '0;
				end
			end
			bps_pkg::ST_MOVE: begin
				if (mul_done && k_q != 2'd2) begin
					k_q <= k_q + 2'd1;
					acc_q <= '0;
					mcand_q <= {{34{vel_q[k_q + 2'd1][31]}}, vel_q[k_q + 2'd1]};
					mplier_q <= {16'd0, dt_q};
				end
			end
			bps_pkg::ST_DIFF: begin
				for (int k = 0; k < 3; k++) begin
					a_q[k] <= diff[k][32] ? 32'(-diff[k]) : diff[k][31:0];
				end
				v0_le0_q <= diff[0][32] || (diff[0] == '0);
				v1_ge0_q <= !diff[1][32];
				v2_neg_q <= diff[2][32];
				k_q <= 2'd0;
				acc_q <= '0;
				mcand_q <= {34'd0, (diff[0][32] ? 32'(-diff[0]) : diff[0][31:0])};
				mplier_q <= diff[0][32] ? 32'(-diff[0]) : diff[0][31:0];
			end
			bps_pkg::ST_SQ: begin
				// The three squares accumulate without clearing; saturate at the end.
				if (mul_done) begin
					if (k_q == 2'd2) begin
						dist_q <= (acc_q[65:64] != 2'd0) ? '1 : acc_q[63:0];
					end else begin
						k_q <= k_q + 2'd1;
						mcand_q <= {34'd0, a_q[k_q + 2'd1]};
						mplier_q <= a_q[k_q + 2'd1];
					end
				end
			end
			bps_pkg::ST_TURN_INIT: begin
				cx_q <= {4'd0, a_q[2] >> s_turn};
				cy_q <= {4'd0, a_q[0] >> s_turn};
				cz_q <= '0;
				cnt_q <= '0;
			end
			bps_pkg::ST_TURN, bps_pkg::ST_TILT: begin
				if (!cordic_done) begin
					if (cy_q > 0) begin
						cx_q <= cx_q + cdx;
						cy_q <= cy_q - cdy;
						cz_q <= cz_q + ctab;
					end else begin
						cx_q <= cx_q - cdx;
						cy_q <= cy_q + cdy;
						cz_q <= cz_q - ctab;
					end
					cnt_q <= cnt_q + bps_pkg::CNT_W'(1);
				end else if (state_q == bps_pkg::ST_TURN) begin
					turn_q <= v0_le0_q ? -turn_ang : turn_ang;
				end else begin
					tilt_q <= v1_ge0_q ? -tilt_ang : tilt_ang;
					acc_q <= '0;
					mcand_q <= {{34{cfg_q[bps_pkg::CFG_GRAVITY][31]}},
						cfg_q[bps_pkg::CFG_GRAVITY]};
					mplier_q <= {16'd0, dt_q};
				end
			end
			bps_pkg::ST_TILT_INIT: begin
				hz_q <= a_q[2] >> s_tilt;
				hy_q <= a_q[1] >> s_tilt;
				k_q <= 2'd0;
				acc_q <= '0;
				mcand_q <= {34'd0, a_q[0] >> s_tilt};
				mplier_q <= a_q[0] >> s_tilt;
			end
			bps_pkg::ST_TILT_SQ: begin
				if (mul_done) begin
					if (k_q == 2'd0) begin
						k_q <= 2'd1;
						mcand_q <= {34'd0, hz_q};
						mplier_q <= hz_q;
					end else begin
						n_q <= acc_q[63:0];
						res_q <= '0;
						bit_q <= 64'd1 << 62;
					end
				end
			end
			bps_pkg::ST_ISQRT: begin
				if (bit_q != '0) begin
					if (n_q >= trial) begin
						n_q <= n_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else if (res_q == '0 && hy_q == '0) begin
					acc_q <= '0;
					mcand_q <= {{34{cfg_q[bps_pkg::CFG_GRAVITY][31]}},
						cfg_q[bps_pkg::CFG_GRAVITY]};
					mplier_q <= {16'd0, dt_q};
				end else begin
					cx_q <= {4'd0, res_q[31:0]};
					cy_q <= {4'd0, hy_q};
					cz_q <= '0;
					cnt_q <= '0;
				end
			end
			default: begin
			end
		endcase

		if (out_load) begin
			o_x_q <= pos_q[0];
			o_y_q <= pos_q[1];
			o_z_q <= pos_q[2];
			o_life_q <= life_q;
			o_turn_q <= turn_q;
			o_tilt_q <= tilt_q;
			o_dist_q <= dist_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.new_x = o_x_q;
	assign out_ch.new_y = o_y_q;
	assign out_ch.new_z = o_z_q;
	assign out_ch.turn_angle = o_turn_q;
	assign out_ch.tilt_angle = o_tilt_q;
	assign out_ch.camera_distance_sq = o_dist_q;
	assign out_ch.life_left = o_life_q;

endmodule
`default_nettype wire

@@ rtl/core/bps_chk.sv @@
`default_nettype none
module bps_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [31:0] out_x,
	input wire logic signed [24:0] turn_angle,
	input wire logic signed [24:0] tilt_angle
);

	// A result stays offered until the receiver takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x))
		else $error("result dropped or changed while stalled");

	// One request at a time: after an accepted transaction the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	a_turn_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_angle >= -bps_pkg::DEG180) && (turn_angle <= bps_pkg::DEG180))
		else $error("turn angle out of range");

	a_tilt_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tilt_angle >= -bps_pkg::DEG90) && (tilt_angle <= bps_pkg::DEG90))
		else $error("tilt angle out of range");

endmodule

bind billboard_particle_step_top bps_chk u_bps_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_x(out_ch.new_x),
	.turn_angle(out_ch.turn_angle),
	.tilt_angle(out_ch.tilt_angle)
);
`default_nettype wire
